>>> rtl/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_pkg
// Shared codes and constants for the hashed timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  localparam int IVL_W = 15;

endpackage : htw_pkg
`default_nettype wire

>>> rtl/hashed_timer_wheel.sv
`timescale 1ns / 1ps
`default_nettype none
// Each item is accepted while idle; the entry ring is then rotated once
// through the head cell, and a wrap-up step strobes the final result.
// Busy stays high from the accept through the wrap-up, so a new item is taken
// only once the last one is finished. Fires come out at most one a cycle.
// The receiver cannot stall; results are never held.
// Reset: slot 0, next id 1, all entries free.
// ----------------------------------------------------------------------------
// hashed_timer_wheel
// Single-level timer wheel over a ring of timer cells scanned in table order.
// ----------------------------------------------------------------------------
module hashed_timer_wheel #(
  parameter int WHEEL_SLOTS = 64,
  parameter int MAX_TIMERS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic signed [15:0] in_delay,
  input  wire logic        in_repeat_req,
  input  wire logic [31:0] in_timer_id,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [31:0]      out_result_id,
  output logic [1:0]       out_status,
  output logic             out_last
);
  import htw_pkg::*;

  localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
  // reciprocal for the interval reduction, exact for any 15-bit interval
  localparam int RED_K  = IVL_W + SLOT_W;
  localparam int RED_M  = ((1 << RED_K) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;
  localparam int PROD_W = 2 * IVL_W + 2;

  // ring storage
  logic              c_valid [MAX_TIMERS];
  logic              c_rep   [MAX_TIMERS];
  logic [SLOT_W-1:0] c_ivl   [MAX_TIMERS];
  logic [SLOT_W-1:0] c_slot  [MAX_TIMERS];
  logic [31:0]       c_tid   [MAX_TIMERS];

  // head cell after update (fed into the tail)
  logic              h_valid, h_rep;
  logic [SLOT_W-1:0] h_ivl;
  logic [SLOT_W-1:0] h_slot;
  logic [31:0]       h_tid;

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        cmd_r;
  logic              pos_r, rep_req_r, done_r;
  logic [SLOT_W-1:0] ivm_r;        // requested interval modulo wheel size
  logic [31:0]       tid_r;
  logic [SLOT_W-1:0] cur_r;
  logic [31:0]       next_id_r;
  logic              pend_r;       // a fire is held to learn if it is last
  logic [31:0]       pend_id_r;

  logic shift;
  assign shift = busy_r && (cnt_r != CNT_W'(MAX_TIMERS));
  assign busy  = busy_r;

  // interval modulo wheel size: reciprocal multiply, then one subtract
  function automatic logic [SLOT_W-1:0] ivl_mod(input logic [IVL_W-1:0] iv);
    logic [PROD_W-1:0] prod;
    logic [IVL_W-1:0]  quo;
    logic [IVL_W-1:0]  rem;
    prod = PROD_W'(iv) * PROD_W'(RED_M);
    quo  = IVL_W'(prod >> RED_K);
    rem  = iv - IVL_W'(quo * IVL_W'(WHEEL_SLOTS));
    return SLOT_W'(rem);
  endfunction

  // slot after a reduced interval; both operands are below the wheel size
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] c,
                                                 input logic [SLOT_W-1:0] iv);
    logic [SLOT_W:0] s;
    s = {1'b0, c} + {1'b0, iv};
    if (s >= (SLOT_W+1)'(WHEEL_SLOTS)) s = s - (SLOT_W+1)'(WHEEL_SLOTS);
    return SLOT_W'(s);
  endfunction

  // requested interval: nonpositive delay means one tick (a refresh keeps the old interval)
  logic             in_pos;
  logic [IVL_W-1:0] in_ivl;
  assign in_pos = (in_delay > 16'sd0);
  assign in_ivl = in_pos ? in_delay[IVL_W-1:0] : IVL_W'(1);

  logic hit, match, tick_hit;

  always_comb begin
    h_valid = c_valid[0];
    h_rep   = c_rep[0];
    h_ivl   = c_ivl[0];
    h_slot  = c_slot[0];
    h_tid   = c_tid[0];
    match    = c_valid[0] && (c_tid[0] == tid_r) && !done_r;
    tick_hit = c_valid[0] && (c_slot[0] == cur_r);
    hit      = 1'b0;
    case (cmd_r)
      CMD_ADD: begin
        if (!c_valid[0] && !done_r) begin
          hit     = 1'b1;
          h_valid = 1'b1;
          h_rep   = rep_req_r;
          h_ivl   = ivm_r;
          h_slot  = slot_add(cur_r, ivm_r);
          h_tid   = next_id_r;
        end
      end
      CMD_CANCEL: begin
        if (match) begin
          hit     = 1'b1;
          h_valid = 1'b0;
        end
      end
      CMD_REFRESH: begin
        if (match) begin
          hit     = 1'b1;
          h_ivl   = pos_r ? ivm_r : c_ivl[0];
          h_slot  = slot_add(cur_r, h_ivl);
        end
      end
      default: begin
        if (tick_hit) begin
          hit = 1'b1;
          if (c_rep[0]) h_slot = slot_add(cur_r, c_ivl[0]);
          else          h_valid = 1'b0;
        end
      end
    endcase
  end

  // ring of cells; cell i takes from i+1, tail takes updated head
  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    if (g == MAX_TIMERS - 1) begin : g_tail
      htw_cell #(.SLOT_W(SLOT_W)) u_cell (
        .clk, .rst_n, .shift,
        .in_valid(h_valid), .in_rep(h_rep), .in_ivl(h_ivl),
        .in_slot(h_slot), .in_tid(h_tid),
        .valid_r(c_valid[g]), .rep_r(c_rep[g]), .ivl_r(c_ivl[g]),
        .slot_r(c_slot[g]), .tid_r(c_tid[g]));
    end else begin : g_mid
      htw_cell #(.SLOT_W(SLOT_W)) u_cell (
        .clk, .rst_n, .shift,
        .in_valid(c_valid[g+1]), .in_rep(c_rep[g+1]), .in_ivl(c_ivl[g+1]),
        .in_slot(c_slot[g+1]), .in_tid(c_tid[g+1]),
        .valid_r(c_valid[g]), .rep_r(c_rep[g]), .ivl_r(c_ivl[g]),
        .slot_r(c_slot[g]), .tid_r(c_tid[g]));
    end
  end

  // sequencer
  logic strobe_r, kind_r, last_r;
  logic [31:0] rid_r;
  logic [1:0]  stat_r;
  logic [SLOT_W-1:0] cur_inc;
  assign cur_inc = (cur_r == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : cur_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      cur_r     <= '0;
      next_id_r <= 32'd1;
      pend_r    <= 1'b0;
      strobe_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r    <= 1'b1;
          cnt_r     <= '0;
          cmd_r     <= in_cmd;
          pos_r     <= in_pos;
          ivm_r     <= ivl_mod(in_ivl);
          rep_req_r <= in_repeat_req;
          tid_r     <= in_timer_id;
          done_r    <= 1'b0;
          pend_r    <= 1'b0;
          if (in_cmd == CMD_TICK) cur_r <= cur_inc;
        end
      end else if (shift) begin
        cnt_r <= cnt_r + 1'b1;
        if (hit) done_r <= 1'b1;
        if (cmd_r == CMD_TICK && hit) begin
          // emit previous held fire, hold this one
          if (pend_r) begin
            strobe_r <= 1'b1;
            kind_r   <= KIND_FIRE;
            rid_r    <= pend_id_r;
            stat_r   <= ST_OK;
            last_r   <= 1'b0;
          end
          pend_r    <= 1'b1;
          pend_id_r <= c_tid[0];
        end
        if (cmd_r == CMD_ADD && hit) begin
          next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 1'b1;
          pend_id_r <= next_id_r;
        end
      end else begin
        // wrap-up cycle
        busy_r   <= 1'b0;
        kind_r   <= KIND_ACK;
        last_r   <= 1'b1;
        stat_r   <= ST_OK;
        case (cmd_r)
          CMD_ADD: begin
            strobe_r <= 1'b1;
            rid_r    <= done_r ? pend_id_r : 32'd0;
            stat_r   <= done_r ? ST_OK : ST_FULL;
          end
          CMD_CANCEL, CMD_REFRESH: begin
            strobe_r <= 1'b1;
            rid_r    <= tid_r;
            stat_r   <= done_r ? ST_OK : ST_NOTFOUND;
          end
          default: begin
            strobe_r <= pend_r;
            kind_r   <= KIND_FIRE;
            rid_r    <= pend_id_r;
          end
        endcase
        pend_r <= 1'b0;
      end
    end
  end

  assign out_strobe    = strobe_r;
  assign out_kind      = kind_r;
  assign out_result_id = rid_r;
  assign out_status    = stat_r;
  assign out_last      = last_r;
endmodule : hashed_timer_wheel
`default_nettype wire

>>> rtl/htw_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_cell
// One timer entry of the rotating table; passes its contents to the cell nearer the head
// every scan cycle so that the head cell is always the one being examined.
// ----------------------------------------------------------------------------
module htw_cell #(
  parameter int SLOT_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift,
  input  wire logic              in_valid,
  input  wire logic              in_rep,
  input  wire logic [SLOT_W-1:0] in_ivl,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [31:0]       in_tid,
  output logic                   valid_r,
  output logic                   rep_r,
  output logic [SLOT_W-1:0]      ivl_r,
  output logic [SLOT_W-1:0]      slot_r,
  output logic [31:0]            tid_r
);
  // control bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= in_valid;
    end
  end

  // payload; the interval is kept reduced modulo the wheel size
  always_ff @(posedge clk) begin
    if (shift) begin
      rep_r  <= in_rep;
      ivl_r  <= in_ivl;
      slot_r <= in_slot;
      tid_r  <= in_tid;
    end
  end
endmodule : htw_cell
`default_nettype wire
